@@ rtl/tsort_pkg.sv @@
package tsort_pkg;

    // fixed field widths of the request, result and config channels
    localparam int unsigned VERT_W = 6;
    localparam int unsigned CFG_W  = 7;

    // input action codes
    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_RUN  = 1'b1;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SWEEP    = 5'b00010,
        S_PICK     = 5'b00100,
        S_OUT_RD   = 5'b01000,
        S_OUT_SEND = 5'b10000
    } t_state;

endpackage

@@ rtl/topological_sort_smallest_first_unit.sv @@
// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+-------------------------------------------
// request   | in        | i_in_valid / o_in_stall  | i_action, i_edge_source, i_edge_target
// result    | out       | o_out_valid / i_out_stall| o_vertex, o_last, o_cycle_found,
//           |           |                          | o_dropped_edges
// config    | in        | i_cfg_we                 | i_cfg_data (vertex count)
//
// Edge requests can be loaded back to back while the unit is idle.
// A run request sweeps the adjacency memory and picks once per sorted vertex plus once more,
// stopping early when a cycle stops the sort; then each result is read from the order
// memory and sent.
// o_in_stall is high from a run request until its last result is taken.
// Synchronous active-low reset empties the graph (per-row valid bits) and sets the
// vertex count to MAX_VERTICES; i_out_stall holds the current result steady.
module topological_sort_smallest_first_unit
    import tsort_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_action,
    input  logic [VERT_W-1:0] i_edge_source,
    input  logic [VERT_W-1:0] i_edge_target,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [VERT_W-1:0] o_vertex,
    output logic              o_last,
    output logic              o_cycle_found,
    output logic              o_dropped_edges
);

    localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

    // lowest set bit of a vertex set
    function automatic logic [AW-1:0] f_lowest(input logic [MAX_VERTICES-1:0] bits);
        logic [AW-1:0] idx;
        idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (bits[i]) idx = AW'(i);
        end
        return idx;
    endfunction

    // memories: adjacency rows and the sorted order
    logic [MAX_VERTICES-1:0] r_adj [MAX_VERTICES];
    logic [AW-1:0]           r_ord [MAX_VERTICES];

    // control and status
    t_state                  r_state;
    logic [CFG_W-1:0]        r_vcount;
    logic [MAX_VERTICES-1:0] r_row_vld;
    logic                    r_drop;
    logic [CW-1:0]           r_n;
    logic [MAX_VERTICES-1:0] r_mask;
    logic [MAX_VERTICES-1:0] r_emit;
    logic [MAX_VERTICES-1:0] r_blk;
    logic [CW-1:0]           r_addr;
    logic [CW-1:0]           r_cnt;
    logic [CW-1:0]           r_k;
    logic                    r_rd_use;
    logic [MAX_VERTICES-1:0] r_rd_row;
    logic [AW-1:0]           r_ord_q;
    logic                    r_out_valid;
    logic                    r_cyc;
    logic                    r_out_drop;

    // effective vertex count, clamped to 1..MAX_VERTICES
    logic [CFG_W-1:0]        eff7;
    logic [CW-1:0]           eff_n;
    logic [MAX_VERTICES-1:0] eff_mask;
    logic                    in_acc;
    logic                    edge_ok;
    logic                    adj_we;
    logic [AW-1:0]           src_a;
    logic [AW-1:0]           tgt_a;
    logic [MAX_VERTICES-1:0] tgt_hot;
    logic                    sweep_rd;
    logic [AW-1:0]           sweep_a;
    logic [MAX_VERTICES-1:0] rdy;
    logic [AW-1:0]           pick_v;
    logic                    k_last;

    always_comb begin
        if (r_vcount == '0) begin
            eff7 = CFG_W'(1);
        end else if (r_vcount > CFG_W'(MAX_VERTICES)) begin
            eff7 = CFG_W'(MAX_VERTICES);
        end else begin
            eff7 = r_vcount;
        end
        eff_n = CW'(eff7);
        for (int i = 0; i < MAX_VERTICES; i++) begin
            eff_mask[i] = (CW'(i) < eff_n);
        end
    end

    // edge load decode
    assign in_acc  = i_in_valid && !o_in_stall;
    assign edge_ok = ({1'b0, i_edge_source} < eff7) && ({1'b0, i_edge_target} < eff7);
    assign adj_we  = in_acc && (i_action == ACT_EDGE) && edge_ok;
    assign src_a   = i_edge_source[AW-1:0];
    assign tgt_a   = i_edge_target[AW-1:0];

    always_comb begin
        tgt_hot        = '0;
        tgt_hot[tgt_a] = 1'b1;
    end

    // sweep read and pick unit
    assign sweep_rd = (r_state == S_SWEEP) && (r_addr < r_n);
    assign sweep_a  = r_addr[AW-1:0];
    assign rdy      = ~r_emit & ~r_blk & r_mask;
    assign pick_v   = f_lowest(rdy);
    assign k_last   = (r_k == r_n - CW'(1));

    // adjacency memory: first write to an empty row replaces it, later writes set one bit
    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            if (r_row_vld[src_a]) begin
                r_adj[src_a][tgt_a] <= 1'b1;
            end else begin
                r_adj[src_a] <= tgt_hot;
            end
        end
        if (sweep_rd) begin
            r_rd_row <= r_adj[sweep_a];
        end
    end

    // order memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_PICK && rdy != '0) begin
            r_ord[r_cnt[AW-1:0]] <= pick_v;
        end
        if (r_state == S_OUT_RD) begin
            r_ord_q <= r_ord[r_k[AW-1:0]];
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= CFG_W'(MAX_VERTICES);
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_data;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_vld   <= '0;
            r_drop      <= 1'b0;
            r_emit      <= '0;
            r_cnt       <= '0;
            r_rd_use    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_action == ACT_EDGE) begin
                            if (edge_ok) begin
                                r_row_vld[src_a] <= 1'b1;
                            end else begin
                                r_drop <= 1'b1;
                            end
                        end else begin
                            r_n      <= eff_n;
                            r_mask   <= eff_mask;
                            r_emit   <= '0;
                            r_cnt    <= '0;
                            r_addr   <= '0;
                            r_blk    <= '0;
                            r_rd_use <= 1'b0;
                            r_state  <= S_SWEEP;
                        end
                    end
                end
                S_SWEEP: begin
                    // gather successors of every vertex not yet emitted
                    r_rd_use <= sweep_rd && r_row_vld[sweep_a] && !r_emit[sweep_a];
                    if (r_rd_use) begin
                        r_blk <= r_blk | r_rd_row;
                    end
                    if (r_addr == r_n) begin
                        r_state <= S_PICK;
                    end else begin
                        r_addr <= r_addr + CW'(1);
                    end
                end
                S_PICK: begin
                    if (rdy != '0) begin
                        r_emit[pick_v] <= 1'b1;
                        r_cnt          <= r_cnt + CW'(1);
                        r_addr         <= '0;
                        r_blk          <= '0;
                        r_state        <= S_SWEEP;
                    end else begin
                        // sort finished or stuck on a cycle; the graph is cleared
                        r_cyc      <= (r_cnt != r_n);
                        r_out_drop <= r_drop;
                        r_drop     <= 1'b0;
                        r_row_vld  <= '0;
                        r_k        <= '0;
                        r_state    <= S_OUT_RD;
                    end
                end
                S_OUT_RD: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT_SEND;
                end
                S_OUT_SEND: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_cyc || k_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + CW'(1);
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ports
    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_vertex        = r_cyc ? '0 : VERT_W'(r_ord_q);
    assign o_last          = r_cyc || k_last;
    assign o_cycle_found   = r_cyc;
    assign o_dropped_edges = r_out_drop;

`ifndef NO_ASSERTIONS
    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == S_OUT_SEND))
        else $error("result valid outside the send state");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_emit) == int'(r_cnt))
        else $error("emitted set does not match the sorted count");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP || r_state == S_PICK) |-> (r_cnt <= r_n))
        else $error("sorted count exceeds vertex count");

    a_cycle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cycle_found) |-> (o_last && o_vertex == '0))
        else $error("cycle result malformed");

    a_graph_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT_RD) |-> (r_row_vld == '0 && !r_drop))
        else $error("graph not cleared after a run");
`endif

endmodule
